// ----- hw/rtl/hsl2rgb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Fixed-point formats, constants and stage payload types of the HSL to RGB
// color generator.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

	// Hue, saturation, lightness and levels share one fraction width.
	localparam int unsigned FRACTION_BITS = 16;
	localparam int unsigned LEVEL_W       = FRACTION_BITS + 1;   // 0..ONE
	localparam int unsigned WIDE_W        = FRACTION_BITS + 2;   // 0..2*ONE and above
	localparam int unsigned PROD_W        = WIDE_W + LEVEL_W;    // ramp product
	localparam int unsigned INDEX_W       = 32;
	localparam int unsigned POS_W         = 64;                  // generated hue position
	localparam int unsigned NUM_CH        = 3;                   // red, green, blue

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	// Operating modes of an input item
	localparam logic MODE_HSL   = 1'b0;
	localparam logic MODE_INDEX = 1'b1;

	typedef logic [FRACTION_BITS-1:0] hue_t;
	typedef logic [LEVEL_W-1:0]       level_t;
	typedef logic [WIDE_W-1:0]        wide_t;

	// Level domain
	localparam level_t ONE_FX  = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam level_t HALF_FX = {2'b01, {(FRACTION_BITS-1){1'b0}}};

	// Hue domain, each rounded to nearest
	localparam hue_t HALF_H       = {1'b1, {(FRACTION_BITS-1){1'b0}}};
	localparam hue_t THIRD_H      = FRACTION_BITS'(((1 << FRACTION_BITS) + 1) / 3);
	localparam hue_t TWO_THIRDS_H = FRACTION_BITS'((2 * (1 << FRACTION_BITS) + 1) / 3);
	localparam hue_t SIXTH_H      = FRACTION_BITS'(((1 << FRACTION_BITS) + 3) / 6);

	// Inverse golden ratio and one third in 64 fraction bits
	localparam logic [INDEX_W-1:0] GOLDEN_HI = 32'h9E3779B9;
	localparam logic [INDEX_W-1:0] GOLDEN_LO = 32'h7F4A7C15;
	localparam logic [POS_W-1:0]   THIRD_64  = 64'h5555555555555555;

	// Section of the piecewise-linear ramp a hue position falls in
	typedef enum logic [1:0] {
		RGN_RISE,
		RGN_HIGH,
		RGN_FALL,
		RGN_LOW
	} rgn_t;

	typedef struct packed {
		logic               mode;
		hue_t               hue;
		level_t             saturation;
		level_t             lightness;
		logic [INDEX_W-1:0] color_index;
	} pix_in_t;

	// Hue and clamped levels after mode selection
	typedef struct packed {
		hue_t   hue;
		level_t sat;
		level_t lit;
	} hsl_t;

	// Per-item ramp setup: levels, per-channel section and slope factor
	typedef struct packed {
		logic                     gray;
		level_t                   lit;
		wide_t                    p;
		wide_t                    d;
		rgn_t   [NUM_CH-1:0]      rgn;
		level_t [NUM_CH-1:0]      f;
	} ramp_t;

	typedef struct packed {
		level_t red;
		level_t green;
		level_t blue;
	} rgb_t;

endpackage

// ----- hw/rtl/hsl2rgb_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_in_if
// Input channel: mode, hue, saturation, lightness and color index.
// ----------------------------------------------------------------------------
interface hsl2rgb_in_if;
	logic                               valid;
	logic                               ready;
	logic                               mode;
	hsl2rgb_pkg::hue_t                  hue;
	hsl2rgb_pkg::level_t                saturation;
	hsl2rgb_pkg::level_t                lightness;
	logic [hsl2rgb_pkg::INDEX_W-1:0]    color_index;

	modport source (
		output valid, mode, hue, saturation, lightness, color_index,
		input  ready
	);
	modport sink (
		input  valid, mode, hue, saturation, lightness, color_index,
		output ready
	);
endinterface

// ----- hw/rtl/hsl2rgb_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_out_if
// Output channel: red, green and blue levels.
// ----------------------------------------------------------------------------
interface hsl2rgb_out_if;
	logic                valid;
	logic                ready;
	hsl2rgb_pkg::level_t red;
	hsl2rgb_pkg::level_t green;
	hsl2rgb_pkg::level_t blue;

	modport source (
		output valid, red, green, blue,
		input  ready
	);
	modport sink (
		input  valid, red, green, blue,
		output ready
	);
endinterface

// ----- hw/rtl/hsl2rgb_hue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_hue
// Stages 1 and 2: clamp saturation and lightness, form the generated hue
// from the color index, select by mode.
// ----------------------------------------------------------------------------
module hsl2rgb_hue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hsl2rgb_pkg::pix_in_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hsl2rgb_pkg::hsl_t    out_data
);

	logic                                valid_s1;
	logic                                mode_s1;
	hsl2rgb_pkg::hue_t                   hue_s1;
	hsl2rgb_pkg::level_t                 sat_s1;
	hsl2rgb_pkg::level_t                 lit_s1;
	logic [hsl2rgb_pkg::INDEX_W-1:0]     prod_hi_s1;
	logic [hsl2rgb_pkg::POS_W-1:0]       prod_lo_s1;
	logic                                valid_s2;
	hsl2rgb_pkg::hsl_t                   hsl_s2;
	logic                                en_s1;
	logic                                en_s2;
	logic [hsl2rgb_pkg::POS_W-1:0]       pos;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage 1: clamp the levels; index times each 32-bit half of the inverse golden ratio
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			mode_s1    <= in_data.mode;
			hue_s1     <= in_data.hue;
			sat_s1     <= (in_data.saturation > hsl2rgb_pkg::ONE_FX) ?
				hsl2rgb_pkg::ONE_FX : in_data.saturation;
			lit_s1     <= (in_data.lightness > hsl2rgb_pkg::ONE_FX) ?
				hsl2rgb_pkg::ONE_FX : in_data.lightness;
			prod_hi_s1 <= in_data.color_index * hsl2rgb_pkg::GOLDEN_HI;
			prod_lo_s1 <= hsl2rgb_pkg::POS_W'(in_data.color_index) *
				hsl2rgb_pkg::POS_W'(hsl2rgb_pkg::GOLDEN_LO);
		end
	end

	// Stage 2: combine partial products and one third modulo 2^64, keep the top fraction bits, select by mode
	assign pos = {prod_hi_s1, {hsl2rgb_pkg::INDEX_W{1'b0}}} + prod_lo_s1 +
		hsl2rgb_pkg::THIRD_64;

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			if (mode_s1 == hsl2rgb_pkg::MODE_INDEX) begin
				hsl_s2.hue <= pos[hsl2rgb_pkg::POS_W-1 -: hsl2rgb_pkg::FRACTION_BITS];
				hsl_s2.sat <= hsl2rgb_pkg::ONE_FX;
				hsl_s2.lit <= hsl2rgb_pkg::HALF_FX;
			end else begin
				hsl_s2.hue <= hue_s1;
				hsl_s2.sat <= sat_s1;
				hsl_s2.lit <= lit_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = hsl_s2;

endmodule

// ----- hw/rtl/hsl2rgb_lvl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_lvl
// Stages 3 and 4: lightness times saturation, then the levels p and q and
// each channel's ramp section and slope factor.
// ----------------------------------------------------------------------------
module hsl2rgb_lvl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsl2rgb_pkg::hsl_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsl2rgb_pkg::ramp_t out_data
);

	localparam int unsigned FB = hsl2rgb_pkg::FRACTION_BITS;

	logic                                   valid_s3;
	hsl2rgb_pkg::hsl_t                      hsl_s3;
	hsl2rgb_pkg::level_t                    m_s3;
	logic                                   valid_s4;
	hsl2rgb_pkg::ramp_t                     ramp_s4;
	logic                                   en_s3;
	logic                                   en_s4;
	logic [2*hsl2rgb_pkg::LEVEL_W-1:0]      ls;
	hsl2rgb_pkg::wide_t                     q_lo;
	hsl2rgb_pkg::wide_t                     q_hi;
	hsl2rgb_pkg::wide_t                     q0;
	hsl2rgb_pkg::wide_t                     q1;
	hsl2rgb_pkg::wide_t                     q2;
	hsl2rgb_pkg::wide_t                     two_l;
	hsl2rgb_pkg::wide_t                     p;
	hsl2rgb_pkg::ramp_t                     ramp_d;

	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 3: floor(l*s/ONE)
	assign ls = in_data.lit * in_data.sat;

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			hsl_s3 <= in_data;
			m_s3   <= ls[FB +: hsl2rgb_pkg::LEVEL_W];
		end
	end

	// Stage 4: levels, then per-channel hue position
	always_comb begin
		hsl2rgb_pkg::hue_t t [hsl2rgb_pkg::NUM_CH];
		logic [FB+2:0]     six;
		hsl2rgb_pkg::hue_t down;

		q_lo  = hsl2rgb_pkg::WIDE_W'(hsl_s3.lit) + hsl2rgb_pkg::WIDE_W'(m_s3);
		q_hi  = hsl2rgb_pkg::WIDE_W'(hsl_s3.lit) + hsl2rgb_pkg::WIDE_W'(hsl_s3.sat) -
			hsl2rgb_pkg::WIDE_W'(m_s3);
		q0    = (hsl_s3.lit < hsl2rgb_pkg::HALF_FX) ? q_lo : q_hi;
		two_l = {hsl_s3.lit, 1'b0};
		q1    = (q0 > two_l) ? two_l : q0;
		p     = two_l - q1;
		q2    = (q1 < p) ? p : q1;

		ramp_d.gray = (hsl_s3.sat == '0);
		ramp_d.lit  = hsl_s3.lit;
		ramp_d.p    = p;
		ramp_d.d    = q2 - p;

		t[hsl2rgb_pkg::CH_RED]   = hsl_s3.hue + hsl2rgb_pkg::THIRD_H;
		t[hsl2rgb_pkg::CH_GREEN] = hsl_s3.hue;
		t[hsl2rgb_pkg::CH_BLUE]  = hsl_s3.hue - hsl2rgb_pkg::THIRD_H;

		for (int k = 0; k < hsl2rgb_pkg::NUM_CH; k++) begin
			down = hsl2rgb_pkg::TWO_THIRDS_H - t[k];
			six  = '0;
			if (t[k] < hsl2rgb_pkg::SIXTH_H) begin
				ramp_d.rgn[k] = hsl2rgb_pkg::RGN_RISE;
				six = ({3'b000, t[k]} << 2) + ({3'b000, t[k]} << 1);
			end else if (t[k] < hsl2rgb_pkg::HALF_H) begin
				ramp_d.rgn[k] = hsl2rgb_pkg::RGN_HIGH;
			end else if (t[k] < hsl2rgb_pkg::TWO_THIRDS_H) begin
				ramp_d.rgn[k] = hsl2rgb_pkg::RGN_FALL;
				six = ({3'b000, down} << 2) + ({3'b000, down} << 1);
			end else begin
				ramp_d.rgn[k] = hsl2rgb_pkg::RGN_LOW;
			end
			ramp_d.f[k] = six[hsl2rgb_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			ramp_s4 <= ramp_d;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = ramp_s4;

`ifndef SYNTH
	// q = p + d never exceeds twice the lightness
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> ({1'b0, ramp_s4.p} + {1'b0, ramp_s4.d}) <= {1'b0, ramp_s4.lit, 1'b0})
		else $error("hsl2rgb_lvl: q above twice the lightness");

	// zero saturation collapses both levels onto the lightness
	a_gray_flat: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && ramp_s4.gray |-> ramp_s4.d == '0)
		else $error("hsl2rgb_lvl: gray item with nonzero level spread");
`endif

endmodule

// ----- hw/rtl/hsl2rgb_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl2rgb_ramp
// Stages 5 and 6: slope products for the three channels, then ramp level,
// clamp and gray override into the output register.
// ----------------------------------------------------------------------------
module hsl2rgb_ramp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsl2rgb_pkg::ramp_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsl2rgb_pkg::rgb_t  out_data
);

	localparam int unsigned FB    = hsl2rgb_pkg::FRACTION_BITS;
	localparam int unsigned SUM_W = hsl2rgb_pkg::PROD_W - FB + 1;

	logic                                     valid_s5;
	logic                                     gray_s5;
	hsl2rgb_pkg::level_t                      lit_s5;
	hsl2rgb_pkg::wide_t                       p_s5;
	hsl2rgb_pkg::wide_t                       q_s5;
	hsl2rgb_pkg::rgn_t                        rgn_s5  [hsl2rgb_pkg::NUM_CH];
	logic [hsl2rgb_pkg::PROD_W-1:0]           prod_s5 [hsl2rgb_pkg::NUM_CH];
	logic                                     valid_s6;
	hsl2rgb_pkg::level_t                      lvl_s6  [hsl2rgb_pkg::NUM_CH];
	logic                                     en_s5;
	logic                                     en_s6;
	hsl2rgb_pkg::level_t                      lvl_d   [hsl2rgb_pkg::NUM_CH];

	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign in_ready = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s5) valid_s5 <= in_valid;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 5: one spread-times-slope product per channel
	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			gray_s5 <= in_data.gray;
			lit_s5  <= in_data.lit;
			p_s5    <= in_data.p;
			q_s5    <= in_data.p + in_data.d;
			for (int k = 0; k < hsl2rgb_pkg::NUM_CH; k++) begin
				rgn_s5[k]  <= in_data.rgn[k];
				prod_s5[k] <= hsl2rgb_pkg::PROD_W'(in_data.d) *
					hsl2rgb_pkg::PROD_W'(in_data.f[k]);
			end
		end
	end

	// Stage 6: pick the section's level, clamp to ONE, or take the lightness for a gray item
	always_comb begin
		logic [SUM_W-1:0] v;
		for (int k = 0; k < hsl2rgb_pkg::NUM_CH; k++) begin
			case (rgn_s5[k])
				hsl2rgb_pkg::RGN_RISE, hsl2rgb_pkg::RGN_FALL:
					v = SUM_W'(p_s5) + SUM_W'(prod_s5[k][hsl2rgb_pkg::PROD_W-1:FB]);
				hsl2rgb_pkg::RGN_HIGH: v = SUM_W'(q_s5);
				default:               v = SUM_W'(p_s5);
			endcase
			if (gray_s5) begin
				lvl_d[k] = lit_s5;
			end else if (v > SUM_W'(hsl2rgb_pkg::ONE_FX)) begin
				lvl_d[k] = hsl2rgb_pkg::ONE_FX;
			end else begin
				lvl_d[k] = v[hsl2rgb_pkg::LEVEL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6 && valid_s5) begin
			for (int k = 0; k < hsl2rgb_pkg::NUM_CH; k++) begin
				lvl_s6[k] <= lvl_d[k];
			end
		end
	end

	assign out_valid      = valid_s6;
	assign out_data.red   = lvl_s6[hsl2rgb_pkg::CH_RED];
	assign out_data.green = lvl_s6[hsl2rgb_pkg::CH_GREEN];
	assign out_data.blue  = lvl_s6[hsl2rgb_pkg::CH_BLUE];

`ifndef SYNTH
	// every delivered level lies in 0..ONE
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> out_data.red <= hsl2rgb_pkg::ONE_FX &&
			out_data.green <= hsl2rgb_pkg::ONE_FX && out_data.blue <= hsl2rgb_pkg::ONE_FX)
		else $error("hsl2rgb_ramp: output level above full scale");

	// an item in stage 5 that may advance reaches the output register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && en_s6 |=> valid_s6)
		else $error("hsl2rgb_ramp: item lost between stage 5 and stage 6");
`endif

endmodule

// ----- hw/rtl/hsl_to_rgb_color_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_color_generator
// HSL to RGB conversion in unsigned fixed point, with an index-driven
// color generator mode, as a six-stage valid/ready pipeline.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake      payload
//  -------  ---------  -------------  ------------------------------------------
//  hsl      in         valid / ready  mode, hue, saturation, lightness, color_index
//  rgb      out        valid / ready  red, green, blue
//
//  One item per cycle sustained while rgb is ready. Accepting an item
//  loads stage 1; the result reaches rgb out of the stage 6 register.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Each stage holds while it is full and the next stage cannot take its
//  item; an empty stage keeps taking items, so bubbles close up under a stall.
//
module hsl_to_rgb_color_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	hsl2rgb_in_if.sink           hsl,
	hsl2rgb_out_if.source        rgb
);

	hsl2rgb_pkg::pix_in_t pix;          // input fields gathered into one word

	logic                 hue_valid;    // stage 2 -> stage 3
	logic                 hue_ready;
	hsl2rgb_pkg::hsl_t    hue_data;

	logic                 lvl_valid;    // stage 4 -> stage 5
	logic                 lvl_ready;
	hsl2rgb_pkg::ramp_t   lvl_data;

	hsl2rgb_pkg::rgb_t    rgb_data;

	assign pix.mode        = hsl.mode;
	assign pix.hue         = hsl.hue;
	assign pix.saturation  = hsl.saturation;
	assign pix.lightness   = hsl.lightness;
	assign pix.color_index = hsl.color_index;

	// Stages 1-2: clamp levels, generate hue from the index, select by mode
	hsl2rgb_hue u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsl.valid),
		.in_ready  (hsl.ready),
		.in_data   (pix),
		.out_valid (hue_valid),
		.out_ready (hue_ready),
		.out_data  (hue_data)
	);

	// Stages 3-4: lightness times saturation, levels p and q, ramp sections
	hsl2rgb_lvl u_lvl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hue_valid),
		.in_ready  (hue_ready),
		.in_data   (hue_data),
		.out_valid (lvl_valid),
		.out_ready (lvl_ready),
		.out_data  (lvl_data)
	);

	// Stages 5-6: slope products, ramp level and clamp; stage 6 is the
	// output register
	hsl2rgb_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lvl_valid),
		.in_ready  (lvl_ready),
		.in_data   (lvl_data),
		.out_valid (rgb.valid),
		.out_ready (rgb.ready),
		.out_data  (rgb_data)
	);

	assign rgb.red   = rgb_data.red;
	assign rgb.green = rgb_data.green;
	assign rgb.blue  = rgb_data.blue;

endmodule

// ----- bench/hsl_to_rgb_color_generator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_color_generator_tb
// Self-checking bench for the HSL to RGB color generator. Every accepted item
// is converted by a fixed-point color model in the bench. The expected color
// is queued, and each color leaving the block is compared channel by channel.
// Directed corner items come first, then random traffic with idling on both
// sides, a back-to-back phase, and a long output stall that backs up the
// pipeline.
// ----------------------------------------------------------------------------
module hsl_to_rgb_color_generator_tb;

	typedef hsl2rgb_pkg::hue_t    hue_t;
	typedef hsl2rgb_pkg::level_t  level_t;
	typedef hsl2rgb_pkg::rgb_t    rgb_t;
	typedef hsl2rgb_pkg::pix_in_t pix_in_t;

	// Operating modes of an input item
	localparam logic MODE_HSL   = hsl2rgb_pkg::MODE_HSL;
	localparam logic MODE_INDEX = hsl2rgb_pkg::MODE_INDEX;

	// Fixed-point constants of the color model, all in 64-bit arithmetic
	localparam int unsigned     FB              = hsl2rgb_pkg::FRACTION_BITS;
	localparam longint unsigned UNIT            = 64'd1 << FB;
	localparam longint unsigned HALF_UNIT       = UNIT >> 1;
	localparam longint unsigned HUE_MASK        = UNIT - 1;
	localparam longint unsigned THIRD_TURN      = (UNIT + 1) / 3;
	localparam longint unsigned TWO_THIRDS_TURN = (2 * UNIT + 1) / 3;
	localparam longint unsigned SIXTH_TURN      = (UNIT + 3) / 6;
	localparam longint unsigned LEVEL_MAX       = (UNIT << 1) - 1;   // all ones, 17 bits

	// Pipeline depth plus margin for the drain at the end of each phase
	localparam int DRAIN_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;

	hsl2rgb_in_if  hsl ();
	hsl2rgb_out_if rgb ();

	hsl_to_rgb_color_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsl    (hsl.sink),
		.rgb    (rgb.source)
	);

	// 12 ns period: low half, then high half
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Colors the block still owes, oldest first
	rgb_t expected_colors[$];
	int   mismatches   = 0;
	int   colors_seen  = 0;

	// Idling switches for each side, and the output hold-off request
	bit src_idle_en  = 1'b0;
	bit sink_idle_en = 1'b0;
	int hold_req     = 0;

	// ------------------------------------------------------------------------
	// Color model
	// ------------------------------------------------------------------------

	function automatic longint unsigned clamp_unit(input longint unsigned v);
		return (v > UNIT) ? UNIT : v;
	endfunction

	// One channel through the piecewise-linear ramp; t is a hue position
	// within one turn, p and q are the low and high levels.
	function automatic longint unsigned ramp_channel(input longint unsigned p,
			input longint unsigned q, input longint unsigned t);
		longint unsigned d;
		longint unsigned v;
		d = q - p;
		if (t < SIXTH_TURN)
			v = p + ((d * 6 * t) >> FB);
		else if (t < HALF_UNIT)
			v = q;
		else if (t < TWO_THIRDS_TURN)
			v = p + ((d * (TWO_THIRDS_TURN - t) * 6) >> FB);
		else
			v = p;
		return clamp_unit(v);
	endfunction

	function automatic rgb_t convert_pixel(input pix_in_t px);
		longint unsigned h, s, l, p, q;
		logic [63:0]     pos;
		rgb_t            c;
		if (px.mode == MODE_INDEX) begin
			// Hue from the golden-ratio walk, 64 fraction bits, keep the top FB
			pos = 64'(px.color_index) * {hsl2rgb_pkg::GOLDEN_HI, hsl2rgb_pkg::GOLDEN_LO} +
				hsl2rgb_pkg::THIRD_64;
			h   = pos >> (64 - FB);
			s   = UNIT;
			l   = HALF_UNIT;
		end else begin
			h = px.hue;
			s = px.saturation;
			l = px.lightness;
		end
		h = h & HUE_MASK;
		s = clamp_unit(s);
		l = clamp_unit(l);
		if (s == 0) begin
			// Gray: every channel sits at the lightness
			c.red   = level_t'(l);
			c.green = level_t'(l);
			c.blue  = level_t'(l);
			return c;
		end
		if (l < HALF_UNIT)
			q = (l * (UNIT + s)) >> FB;
		else
			q = l + s - ((l * s) >> FB);
		if (q > 2 * l)
			q = 2 * l;
		p = 2 * l - q;
		if (q < p)
			q = p;
		c.red   = level_t'(ramp_channel(p, q, (h + THIRD_TURN) & HUE_MASK) & LEVEL_MAX);
		c.green = level_t'(ramp_channel(p, q, h) & LEVEL_MAX);
		c.blue  = level_t'(ramp_channel(p, q, (h + UNIT - THIRD_TURN) & HUE_MASK) & LEVEL_MAX);
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic pix_in_t make_pixel(input logic mode, input hue_t hue,
			input level_t sat, input level_t lit,
			input logic [hsl2rgb_pkg::INDEX_W-1:0] idx);
		pix_in_t px;
		px.mode        = mode;
		px.hue         = hue;
		px.saturation  = sat;
		px.lightness   = lit;
		px.color_index = idx;
		return px;
	endfunction

	// Bias levels toward zero, full, above full and the lightness midpoint
	function automatic level_t random_level();
		case ($urandom_range(7))
			0:       return '0;
			1:       return level_t'(UNIT);
			2:       return level_t'($urandom_range(int'(LEVEL_MAX), int'(UNIT) + 1));
			3:       return level_t'(HALF_UNIT - 1 + $urandom_range(2));
			default: return level_t'($urandom_range(int'(UNIT) - 1, 1));
		endcase
	endfunction

	function automatic pix_in_t random_pixel();
		logic [hsl2rgb_pkg::INDEX_W-1:0] idx;
		idx = $urandom;
		// Small indices now and then: the start of the color sequence
		if ($urandom_range(7) == 0)
			idx = $urandom_range(63);
		return make_pixel($urandom_range(1) ? MODE_INDEX : MODE_HSL, hue_t'($urandom),
			random_level(), random_level(), idx);
	endfunction

	// Offer one item; return at the falling edge after it was taken.
	// Valid stays high on return so the next item follows without a gap.
	task automatic send_pixel(input pix_in_t px);
		if (src_idle_en) begin
			while ($urandom_range(99) < 24) begin
				hsl.valid <= 1'b0;
				@(negedge clk);
			end
		end
		hsl.valid       <= 1'b1;
		hsl.mode        <= px.mode;
		hsl.hue         <= px.hue;
		hsl.saturation  <= px.saturation;
		hsl.lightness   <= px.lightness;
		hsl.color_index <= px.color_index;
		do
			@(posedge clk);
		while (!hsl.ready);
		expected_colors.push_back(convert_pixel(px));
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed color, then let the pipeline settle
	task automatic drain_colors();
		hsl.valid <= 1'b0;
		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t ns: color %0d: %s", $time, colors_seen, msg);
		mismatches++;
	endtask

	task automatic check_level(input string name, input level_t got, input level_t want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%05h, want 0x%05h", name, got, want));
	endtask

	// Compare each color taken from the block with the oldest expected one
	always @(posedge clk) begin : color_check
		rgb_t want;
		if (arst_n === 1'b1 && rgb.valid === 1'b1 && rgb.ready === 1'b1) begin
			if (expected_colors.size() == 0) begin
				report_mismatch("color with none expected");
			end else begin
				want = expected_colors.pop_front();
				check_level("red",   rgb.red,   want.red);
				check_level("green", rgb.green, want.green);
				check_level("blue",  rgb.blue,  want.blue);
			end
			colors_seen++;
		end
	end

	// Output side: random idling, or a counted hold-off when one is requested
	always @(negedge clk) begin : color_sink
		int hold_left;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			rgb.ready <= 1'b0;
			hold_left--;
		end else begin
			rgb.ready <= !(sink_idle_en && $urandom_range(99) < 24);
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corners: gray, black, white, clamping above full, every ramp boundary
	// of the green channel, and the index mode with junk in the unused fields.
	task automatic test_directed();
		pix_in_t items[$];
		items.push_back(make_pixel(MODE_HSL, 16'h1234, '0, level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, 16'hFFFF, '0, level_t'(UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, 16'h0000, level_t'(UNIT), '0, '0));
		items.push_back(make_pixel(MODE_HSL, 16'h4000, level_t'(UNIT), level_t'(UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, 16'hFFFF, '1, '1, '1));
		items.push_back(make_pixel(MODE_HSL, 16'h0000, '1, level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, hue_t'(SIXTH_TURN - 1), level_t'(UNIT),
			level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, hue_t'(SIXTH_TURN), level_t'(UNIT),
			level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, hue_t'(HALF_UNIT - 1), level_t'(UNIT),
			level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, hue_t'(HALF_UNIT), level_t'(UNIT),
			level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, hue_t'(TWO_THIRDS_TURN - 1), level_t'(UNIT),
			level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, hue_t'(TWO_THIRDS_TURN), level_t'(UNIT),
			level_t'(HALF_UNIT), '0));
		items.push_back(make_pixel(MODE_HSL, 16'hFFFF, level_t'(UNIT),
			level_t'(HALF_UNIT - 1), '0));
		items.push_back(make_pixel(MODE_HSL, 16'h2AAA, level_t'(HALF_UNIT),
			level_t'(HALF_UNIT - 1), '0));
		items.push_back(make_pixel(MODE_HSL, 16'h9000, 17'd1, 17'd1, '0));
		items.push_back(make_pixel(MODE_HSL, 16'hC000, 17'd1, level_t'(UNIT - 1), '0));
		items.push_back(make_pixel(MODE_INDEX, '0, '0, '0, 32'd0));
		items.push_back(make_pixel(MODE_INDEX, '0, '0, '0, 32'd1));
		items.push_back(make_pixel(MODE_INDEX, '1, '1, '1, 32'hFFFF_FFFF));
		items.push_back(make_pixel(MODE_INDEX, 16'h5A5A, level_t'(UNIT), '0, 32'h8000_0000));
		foreach (items[i])
			send_pixel(items[i]);
		drain_colors();
	endtask

	// Mixed random traffic with both sides idling at random
	task automatic test_random_traffic(input int count);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		repeat (count) send_pixel(random_pixel());
		drain_colors();
	endtask

	// Long stretch with no idling at all: one item per cycle through
	task automatic test_back_to_back(input int count);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		repeat (count) send_pixel(random_pixel());
		drain_colors();
	endtask

	// Hold the output off long enough to fill the pipeline while items keep
	// coming, so the input stalls; then release and let everything through.
	task automatic test_output_stall(input int count);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		hold_req     = 300;
		repeat (count) send_pixel(random_pixel());
		drain_colors();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		// Drive every input to a known value before the first edge
		arst_n          = 1'b0;
		hsl.valid       = 1'b0;
		hsl.mode        = MODE_HSL;
		hsl.hue         = '0;
		hsl.saturation  = '0;
		hsl.lightness   = '0;
		hsl.color_index = '0;
		rgb.ready       = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_traffic(450);
		test_back_to_back(150);
		test_output_stall(80);
		test_random_traffic(200);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
